@@ sv/audio_channel_router_macros.svh @@
`ifndef AUDIO_CHANNEL_ROUTER_MACROS_SVH
`define AUDIO_CHANNEL_ROUTER_MACROS_SVH

// Concurrent assertion helpers, compiled out for synthesis.

`ifndef SYNTHESIS
`define ACR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define ACR_ASSERT_IMP(label, clk, rst, ante, cons)
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/acr_pkg.sv @@
`default_nettype none

package acr_pkg;

   localparam int CHAN_SLOTS   = 8;
   localparam int CHAN_W       = 3;
   localparam int SAMPLE_W     = 64;
   localparam int CFG_W        = 4;
   localparam int ROUTE_W      = 48;
   localparam int PAIR_W       = 6;
   localparam int MAX_CHANNELS = 8;
   localparam int BANK_W       = 1;
   localparam int BANK_COUNT   = 2 ** BANK_W;
   localparam int RAM_DEPTH    = BANK_COUNT * CHAN_SLOTS;
   localparam int RAM_ADDR_W   = BANK_W + CHAN_W;
   localparam int QPTR_W       = 1;
   localparam int QUEUE_DEPTH  = 2 ** QPTR_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = ROUTE_W;

   localparam logic [CSR_INDEX_W-1:0] REG_IN_CHANNELS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_CHANNELS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROUTE_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROUTE_TABLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_BYTES = 3'd4;

   localparam logic [CFG_W-1:0]   RESET_IN_CHANNELS  = 4'd2;
   localparam logic [CFG_W-1:0]   RESET_OUT_CHANNELS = 4'd2;
   localparam logic [CFG_W-1:0]   RESET_ROUTE_COUNT  = 4'd2;
   localparam logic [ROUTE_W-1:0] RESET_ROUTE_TABLE  = 48'd3072;
   localparam logic [CFG_W-1:0]   RESET_SAMPLE_BYTES = 4'd2;

   typedef struct packed {
      logic [CFG_W-1:0]   in_channels;
      logic [CFG_W-1:0]   out_channels;
      logic [CFG_W-1:0]   route_count;
      logic [ROUTE_W-1:0] route_table;
      logic [CFG_W-1:0]   sample_bytes;
   } cfg_type;

   typedef struct packed {
      logic [BANK_W-1:0]                  bank;
      logic [CHAN_W-1:0]                  last_chan;
      logic [CFG_W-1:0]                   sample_bytes;
      logic [CHAN_SLOTS-1:0][CHAN_W-1:0]  src;
      logic [CHAN_SLOTS-1:0]              hit;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } rel_type;

   function automatic logic [CFG_W-1:0] clamp_channels(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > CFG_W'(MAX_CHANNELS)) begin
         r = CFG_W'(MAX_CHANNELS);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic sample_size_ok(input logic [CFG_W-1:0] b);
      return (b == 4'd1) || (b == 4'd2) || (b == 4'd3) || (b == 4'd4) || (b == 4'd8);
   endfunction

   function automatic logic [SAMPLE_W-1:0] sample_mask(input logic [CFG_W-1:0] b);
      logic [SAMPLE_W-1:0] m;
      unique case (b)
         4'd1: m = 64'h0000_0000_0000_00FF;
         4'd2: m = 64'h0000_0000_0000_FFFF;
         4'd3: m = 64'h0000_0000_00FF_FFFF;
         4'd4: m = 64'h0000_0000_FFFF_FFFF;
         4'd8: m = 64'hFFFF_FFFF_FFFF_FFFF;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

@@ sv/acr_ram.sv @@
`default_nettype none

module acr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/acr_front.sv @@
`default_nettype none

module acr_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire acr_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [acr_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  wire acr_pkg::rel_type              rel,
   output logic                               ram_we,
   output logic      [acr_pkg::RAM_ADDR_W-1:0] ram_waddr,
   output logic      [acr_pkg::SAMPLE_W-1:0]  ram_wdata,
   output logic                               q_push,
   output acr_pkg::cmd_type                   q_cmd
);

   import acr_pkg::*;

   logic [CHAN_W-1:0]     fill_ff, fill_in;
   logic [BANK_W-1:0]     bank_ff, bank_in;
   logic [BANK_COUNT-1:0] busy_ff, busy_in;

   logic [CFG_W-1:0] nin, nout;
   logic             accept, complete, routes_ok, size_ok;
   logic [CHAN_SLOTS-1:0][CHAN_W-1:0] sel;
   logic [CHAN_SLOTS-1:0]             found;

   assign nin       = clamp_channels(cfg.in_channels);
   assign nout      = clamp_channels(cfg.out_channels);
   assign req_ready = !busy_ff[bank_ff];
   assign accept    = req_valid && req_ready;
   assign complete  = ({1'b0, fill_ff} + CFG_W'(1)) >= nin;
   assign size_ok   = sample_size_ok(cfg.sample_bytes);

   always_comb begin
      logic [CHAN_W-1:0] src_i, dst_i;
      routes_ok = (cfg.route_count >= CFG_W'(1)) && (cfg.route_count <= CFG_W'(MAX_CHANNELS));
      for (int i = 0; i < CHAN_SLOTS; i++) begin
         src_i = cfg.route_table[PAIR_W*i +: CHAN_W];
         dst_i = cfg.route_table[PAIR_W*i+CHAN_W +: CHAN_W];
         if ((CFG_W'(i) < cfg.route_count) &&
             (({1'b0, src_i} >= nin) || ({1'b0, dst_i} >= nout))) begin
            routes_ok = 1'b0;
         end
      end
   end

   // The last matching pair in table order wins for each output channel.
   always_comb begin
      logic [CHAN_W-1:0] src_i, dst_i;
      for (int c = 0; c < CHAN_SLOTS; c++) begin
         found[c] = 1'b0;
         sel[c]   = '0;
         for (int i = 0; i < CHAN_SLOTS; i++) begin
            src_i = cfg.route_table[PAIR_W*i +: CHAN_W];
            dst_i = cfg.route_table[PAIR_W*i+CHAN_W +: CHAN_W];
            if ((CFG_W'(i) < cfg.route_count) && (dst_i == CHAN_W'(c))) begin
               found[c] = 1'b1;
               sel[c]   = src_i;
            end
         end
      end
   end

   always_comb begin
      q_cmd.bank         = bank_ff;
      q_cmd.last_chan    = CHAN_W'(nout - CFG_W'(1));
      q_cmd.sample_bytes = cfg.sample_bytes;
      q_cmd.src          = sel;
      q_cmd.hit          = found & {CHAN_SLOTS{size_ok && routes_ok}};
   end

   assign q_push    = accept && complete;
   assign ram_we    = accept;
   assign ram_waddr = {bank_ff, fill_ff};
   assign ram_wdata = req_sample_in;

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         if (complete) begin
            fill_in          = '0;
            bank_in          = bank_ff + BANK_W'(1);
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = fill_ff + CHAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= '0;
         busy_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/acr_queue.sv @@
`default_nettype none

module acr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire acr_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  head_valid,
   output acr_pkg::cmd_type      head_cmd,
   output logic                  full
);

   import acr_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/acr_back.sv @@
`default_nettype none

module acr_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           head_valid,
   input  wire acr_pkg::cmd_type               head_cmd,
   output logic                                pop,
   output acr_pkg::rel_type                    rel,
   output logic                                ram_re,
   output logic      [acr_pkg::RAM_ADDR_W-1:0] ram_raddr,
   input  wire logic [acr_pkg::SAMPLE_W-1:0]   ram_rdata,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [acr_pkg::SAMPLE_W-1:0]   rsp_sample_out,
   output logic      [acr_pkg::CHAN_W-1:0]     rsp_channel_index,
   output logic                                rsp_frame_last
);

   import acr_pkg::*;

   logic [CHAN_W-1:0] ch_ff, ch_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAN_W-1:0] s1_chan_ff;
   logic              s1_last_ff;
   logic              s1_hit_ff;
   logic [CFG_W-1:0]  s1_bytes_ff;

   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [CHAN_W-1:0]   out_chan_ff;
   logic                out_last_ff;

   logic issue, advance, s1_free, last_issue;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign s1_free    = !s1_valid_ff || advance;
   assign issue      = head_valid && s1_free;
   assign last_issue = issue && (ch_ff == head_cmd.last_chan);

   assign ram_re    = issue;
   assign ram_raddr = {head_cmd.bank, head_cmd.src[ch_ff]};
   assign pop       = last_issue;

   always_comb begin
      rel.valid = last_issue;
      rel.bank  = head_cmd.bank;
   end

   always_comb begin
      ch_in = ch_ff;
      if (last_issue) begin
         ch_in = '0;
      end else if (issue) begin
         ch_in = ch_ff + CHAN_W'(1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign out_sample_in = s1_hit_ff ? (ram_rdata & sample_mask(s1_bytes_ff)) : '0;

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_chan_ff  <= ch_ff;
         s1_last_ff  <= (ch_ff == head_cmd.last_chan);
         s1_hit_ff   <= head_cmd.hit[ch_ff];
         s1_bytes_ff <= head_cmd.sample_bytes;
      end
      if (advance) begin
         out_sample_ff <= out_sample_in;
         out_chan_ff   <= s1_chan_ff;
         out_last_ff   <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ch_ff        <= ch_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_sample_out    = out_sample_ff;
   assign rsp_channel_index = out_chan_ff;
   assign rsp_frame_last    = out_last_ff;

endmodule

`default_nettype wire

@@ sv/audio_channel_router.sv @@
// Audio channel router: gathers interleaved samples into frames and emits a
// remapped output frame per input frame.
// Input channel (req_): one sample per transaction; its channel is its place
// in the frame. Up to one transaction per cycle is taken.
// Output channel (rsp_): after the transaction that completes a frame, the
// output frame appears as one transaction per output channel, channel 0
// first, with rsp_frame_last on the last one. The first output transaction
// passes through the command queue, the sample RAM read and the output register,
// and the rest follow at one per cycle while the receiver takes them.
// Each frame is held in one of two banks of the sample RAM; a two-entry
// command queue links the gathering side to the output side. Input stalls
// only when both banks hold frames not yet fully read out, so a stalled
// receiver back-pressures the input after about two frames.
// Configuration (csr_): one register write per cycle with csr_we; writes
// must be made while the block is idle; the block itself does not enforce this.
// Reset: synchronous, active high; clears the frame position, the queue and
// the output register, and loads the default registers. The sample RAM is
// not cleared.

`default_nettype none

`include "audio_channel_router_macros.svh"

module audio_channel_router (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [acr_pkg::SAMPLE_W-1:0]    req_sample_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [acr_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   output logic      [acr_pkg::CHAN_W-1:0]      rsp_channel_index,
   output logic                                 rsp_frame_last,
   input  wire logic                            csr_we,
   input  wire logic [acr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [acr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import acr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   rel_type                rel;
   logic                   ram_we, ram_re;
   logic [RAM_ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0]    ram_wdata, ram_rdata;
   logic                   q_push, q_pop, q_head_valid, q_full;
   cmd_type                q_push_cmd, q_head_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_IN_CHANNELS:  cfg_in.in_channels  = csr_wdata[CFG_W-1:0];
            REG_OUT_CHANNELS: cfg_in.out_channels = csr_wdata[CFG_W-1:0];
            REG_ROUTE_COUNT:  cfg_in.route_count  = csr_wdata[CFG_W-1:0];
            REG_ROUTE_TABLE:  cfg_in.route_table  = csr_wdata[ROUTE_W-1:0];
            REG_SAMPLE_BYTES: cfg_in.sample_bytes = csr_wdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= RESET_IN_CHANNELS;
         cfg_ff.out_channels <= RESET_OUT_CHANNELS;
         cfg_ff.route_count  <= RESET_ROUTE_COUNT;
         cfg_ff.route_table  <= RESET_ROUTE_TABLE;
         cfg_ff.sample_bytes <= RESET_SAMPLE_BYTES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   acr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rel           (rel),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .q_push        (q_push),
      .q_cmd         (q_push_cmd)
   );

   acr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .full       (q_full)
   );

   acr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   acr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_head_valid),
      .head_cmd          (q_head_cmd),
      .pop               (q_pop),
      .rel               (rel),
      .ram_re            (ram_re),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_channel_index (rsp_channel_index),
      .rsp_frame_last    (rsp_frame_last)
   );

   `ACR_ASSERT_IMP(a_push_has_room, clock, reset, q_push, !q_full)
   `ACR_ASSERT_IMP(a_pop_has_entry, clock, reset, q_pop, q_head_valid)
   `ACR_ASSERT_IMP(a_full_stalls_input, clock, reset, q_full, !req_ready)
   `ACR_ASSERT_IMP(a_release_other_bank, clock, reset, rel.valid && q_push, rel.bank != q_push_cmd.bank)
   `ACR_ASSERT_NEXT(a_push_lands, clock, reset, q_push, q_head_valid)

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import acr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS = 64;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   chan;
      logic                last;
   } out_sample_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_sample_out;
   logic [CHAN_W-1:0]      rsp_channel_index;
   logic                   rsp_frame_last;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   audio_channel_router DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out),
      .rsp_channel_index(rsp_channel_index),
      .rsp_frame_last(rsp_frame_last),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   logic [CFG_W-1:0]    in_ch_reg;
   logic [CFG_W-1:0]    out_ch_reg;
   logic [CFG_W-1:0]    route_cnt_reg;
   logic [ROUTE_W-1:0]  route_reg;
   logic [CFG_W-1:0]    bytes_reg;
   logic [SAMPLE_W-1:0] frame_buf [CHAN_SLOTS];
   logic [CHAN_W-1:0]   fill_pos;
   out_sample_type      routed_samples[$];
   out_sample_type      oldest;

   int errors = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   bit gaps_on = 1'b0;
   int burst_left = 0;

   function automatic int unsigned eff_channels(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_CHANNELS) return MAX_CHANNELS;
      return 32'(v);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[CSR_DATA_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pad_field(logic [CFG_W-1:0] v);
      logic [CSR_DATA_W-1:0] r;
      r = rand48();
      r[CFG_W-1:0] = v;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [ROUTE_W-1:0] route_pair(int i, int src, int dst);
      logic [ROUTE_W-1:0] r;
      r = '0;
      r[PAIR_W*i +: 3] = CHAN_W'(src);
      r[PAIR_W*i+3 +: 3] = CHAN_W'(dst);
      return r;
   endfunction

   task automatic reset_model();
      in_ch_reg = RESET_IN_CHANNELS;
      out_ch_reg = RESET_OUT_CHANNELS;
      route_cnt_reg = RESET_ROUTE_COUNT;
      route_reg = RESET_ROUTE_TABLE;
      bytes_reg = RESET_SAMPLE_BYTES;
      fill_pos = '0;
      frame_buf = '{default: '0};
   endtask

   task automatic apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_IN_CHANNELS:  in_ch_reg = data[CFG_W-1:0];
         REG_OUT_CHANNELS: out_ch_reg = data[CFG_W-1:0];
         REG_ROUTE_COUNT:  route_cnt_reg = data[CFG_W-1:0];
         REG_ROUTE_TABLE:  route_reg = data[ROUTE_W-1:0];
         REG_SAMPLE_BYTES: bytes_reg = data[CFG_W-1:0];
         default: ;
      endcase
   endtask

   // Stores one sample and, when it closes the frame, queues the remapped output frame.
   task automatic gather_and_route(logic [SAMPLE_W-1:0] s);
      int unsigned nin;
      int unsigned nout;
      logic [CHAN_W-1:0] src;
      logic [CHAN_W-1:0] dst;
      logic [SAMPLE_W-1:0] routed [CHAN_SLOTS];
      logic [SAMPLE_W-1:0] keep;
      bit usable;
      out_sample_type r;
      nin = eff_channels(in_ch_reg);
      nout = eff_channels(out_ch_reg);
      frame_buf[fill_pos] = s;
      if (fill_pos + 1 < nin) begin
         fill_pos++;
         return;
      end
      fill_pos = '0;
      usable = 1'b1;
      keep = '0;
      case (bytes_reg)
         4'd1, 4'd2, 4'd3, 4'd4, 4'd8: keep = {SAMPLE_W{1'b1}} >> (SAMPLE_W - 8 * bytes_reg);
         default: usable = 1'b0;
      endcase
      if (route_cnt_reg < 1 || route_cnt_reg > MAX_CHANNELS) usable = 1'b0;
      routed = '{default: '0};
      if (usable) begin
         for (int i = 0; i < route_cnt_reg; i++) begin
            src = route_reg[PAIR_W*i +: 3];
            dst = route_reg[PAIR_W*i+3 +: 3];
            if (src >= nin || dst >= nout) usable = 1'b0;
         end
      end
      if (usable) begin
         for (int i = 0; i < route_cnt_reg; i++) begin
            src = route_reg[PAIR_W*i +: 3];
            dst = route_reg[PAIR_W*i+3 +: 3];
            routed[dst] = frame_buf[src] & keep;
         end
      end
      for (int c = 0; c < nout; c++) begin
         r.sample = routed[CHAN_W'(c)];
         r.chan = CHAN_W'(c);
         r.last = (c == nout - 1);
         routed_samples.push_back(r);
      end
   endtask

   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = $urandom_range(12, 1);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      gather_and_route(s);
      if (burst_left > 0) burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (routed_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
   endtask

   task automatic load_config(logic [CFG_W-1:0] nin, logic [CFG_W-1:0] nout,
                              logic [CFG_W-1:0] rcount, logic [ROUTE_W-1:0] routes,
                              logic [CFG_W-1:0] nbytes);
      wait_idle();
      write_reg(REG_IN_CHANNELS, pad_field(nin));
      write_reg(REG_OUT_CHANNELS, pad_field(nout));
      write_reg(REG_ROUTE_COUNT, pad_field(rcount));
      write_reg(REG_ROUTE_TABLE, routes);
      write_reg(REG_SAMPLE_BYTES, pad_field(nbytes));
      write_reg(REG_UNUSED, rand48());
      csr_we <= 1'b0;
   endtask

   task automatic random_setup();
      logic [CFG_W-1:0] sizes [5] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd8};
      logic [CFG_W-1:0] nin;
      logic [CFG_W-1:0] nout;
      logic [CFG_W-1:0] rcount;
      logic [CFG_W-1:0] nbytes;
      logic [ROUTE_W-1:0] routes;
      nin = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(15)) : CFG_W'($urandom_range(8, 1));
      nout = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(15)) : CFG_W'($urandom_range(8, 1));
      rcount = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(15))
                                        : CFG_W'($urandom_range(8, 1));
      nbytes = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(15))
                                        : sizes[3'($urandom_range(4))];
      routes = rand48();
      for (int i = 0; i < rcount && i < CHAN_SLOTS; i++) begin
         routes[PAIR_W*i +: 3] = CHAN_W'($urandom_range(eff_channels(nin) - 1));
         routes[PAIR_W*i+3 +: 3] = CHAN_W'($urandom_range(eff_channels(nout) - 1));
      end
      if ($urandom_range(9) == 0) begin
         routes[PAIR_W*$urandom_range(7) +: PAIR_W] = PAIR_W'($urandom_range(63));
      end
      load_config(nin, nout, rcount, routes, nbytes);
   endtask

   task automatic test_defaults();
      gaps_on = 1'b0;
      stall_pct = 0;
      send_sample('1);
      send_sample('0);
      send_sample(64'h0123_4567_89AB_CDEF);
      send_sample('1);
   endtask

   task automatic test_sample_widths();
      logic [CFG_W-1:0] widths [6] = '{4'd1, 4'd3, 4'd4, 4'd8, 4'd6, 4'd0};
      for (int i = 0; i < 6; i++) begin
         load_config(1, 2, 2, route_pair(0, 0, 0) | route_pair(1, 0, 1), widths[i]);
         send_sample('1);
      end
   endtask

   task automatic test_channel_extremes();
      logic [ROUTE_W-1:0] reversed;
      reversed = '0;
      for (int i = 0; i < CHAN_SLOTS; i++) reversed |= route_pair(i, i, CHAN_SLOTS - 1 - i);
      load_config(8, 8, 8, reversed, 8);
      for (int i = 0; i < CHAN_SLOTS; i++) send_sample(rand_sample());
      // Zero input channels act as one, fifteen output channels act as eight.
      load_config(0, 15, 1, route_pair(0, 0, 7), 8);
      send_sample(64'hFEDC_BA98_7654_3210);
   endtask

   task automatic test_bad_routes();
      load_config(1, 2, 0, route_pair(0, 0, 0), 8);
      send_sample('1);
      load_config(1, 2, 9, '0, 8);
      send_sample('1);
      load_config(1, 2, 1, route_pair(0, 1, 0), 8);
      send_sample('1);
      load_config(1, 2, 1, route_pair(0, 0, 2), 8);
      send_sample('1);
   endtask

   task automatic test_route_priority();
      load_config(2, 2, 3, route_pair(0, 0, 0) | route_pair(1, 1, 0) | route_pair(2, 1, 1), 8);
      send_sample(64'h1111_2222_3333_4444);
      send_sample(64'h5555_6666_7777_8888);
   endtask

   task automatic test_mid_frame_change();
      load_config(4, 2, 2, route_pair(0, 0, 0) | route_pair(1, 1, 1), 8);
      send_sample(64'hAAAA_AAAA_AAAA_AAAA);
      load_config(2, 2, 2, route_pair(0, 0, 0) | route_pair(1, 1, 1), 8);
      send_sample(64'h5555_5555_5555_5555);
   endtask

   task automatic test_backpressure();
      logic [ROUTE_W-1:0] routes;
      routes = '0;
      for (int i = 0; i < CHAN_SLOTS; i++) routes |= route_pair(i, $urandom_range(1), i);
      load_config(2, 8, 8, routes, 8);
      gaps_on = 1'b0;
      stall_pct = 0;
      hold_request = 80;
      for (int i = 0; i < 24; i++) send_sample(rand_sample());
      wait_idle();
   endtask

   task automatic test_random();
      int sent;
      int count;
      int pcts [4] = '{0, 10, 30, 60};
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         random_setup();
         stall_pct = pcts[2'($urandom_range(3))];
         gaps_on = ($urandom_range(3) != 0);
         burst_left = 0;
         count = $urandom_range(4, 1) * eff_channels(in_ch_reg);
         if ($urandom_range(3) == 0) count += $urandom_range(eff_channels(in_ch_reg) - 1);
         for (int i = 0; i < count; i++) send_sample(rand_sample());
         sent += count;
      end
   endtask

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (routed_samples.size() == 0) begin
            $display("%0t: unexpected output transaction: channel %0d, sample %h",
                     $time, rsp_channel_index, rsp_sample_out);
            errors++;
         end else begin
            oldest = routed_samples.pop_front();
            if (rsp_sample_out !== oldest.sample) begin
               $display("%0t: sample_out expected %h, actual %h",
                        $time, oldest.sample, rsp_sample_out);
               errors++;
            end
            if (rsp_channel_index !== oldest.chan) begin
               $display("%0t: channel_index expected %0d, actual %0d",
                        $time, oldest.chan, rsp_channel_index);
               errors++;
            end
            if (rsp_frame_last !== oldest.last) begin
               $display("%0t: frame_last expected %b, actual %b",
                        $time, oldest.last, rsp_frame_last);
               errors++;
            end
         end
      end
   end

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_sample_widths();
      test_channel_extremes();
      test_bad_routes();
      test_route_priority();
      test_mid_frame_change();
      test_backpressure();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
